// ===== hw/rtl/sbat_pkg.sv =====
`timescale 1ns / 1ps

package sbat_pkg;

  // field widths
  localparam int unsigned PeerW  = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IdW    = 32;
  localparam int unsigned CauseW = 8;
  localparam int unsigned NodeW  = 8;
  localparam int unsigned LocalW = 4;

  // highest valid node number
  localparam int unsigned NodeCount = 10;

  // peer mask field
  localparam logic [PeerW-1:0] PeerFieldMask = 10'h3FF;

  // opcodes
  localparam logic [1:0] OpBegin = 2'd0;
  localparam logic [1:0] OpAck   = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  // message kinds
  localparam logic [1:0] KindStopReq = 2'd0;
  localparam logic [1:0] KindStopAck = 2'd1;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadArg   = 2'd1;
  localparam logic [1:0] StBadValue = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

  // register indexes
  localparam logic [1:0] RegLocalNode     = 2'd0;
  localparam logic [1:0] RegPeerSet       = 2'd1;
  localparam logic [1:0] RegRetryInterval = 2'd2;

  // reset values of the registers
  localparam logic [LocalW-1:0] LocalNodeRst     = 4'd1;
  localparam logic [TimeW-1:0]  RetryIntervalRst = 32'd1000;

  // node number in range
  function automatic logic node_ok(logic [NodeW-1:0] node);
    return (node >= NodeW'(1)) && (node <= NodeW'(NodeCount));
  endfunction

  // mask bit of a node, empty when the node is out of range
  function automatic logic [PeerW-1:0] node_bit(logic [NodeW-1:0] node);
    logic [PeerW-1:0] m;
    m = '0;
    if (node_ok(node) && (node <= NodeW'(PeerW))) begin
      m = PeerW'(1) << (node - NodeW'(1));
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/stop_broadcast_ack_tracker.sv =====
`timescale 1ns / 1ps

// channel  | valid / ready             | payload
// ---------+---------------------------+--------------------------------------------
// cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// in       | in_valid_i / in_ready_o   | opcode, now_time, msg_kind, msg_source,
//          |                           | bound_source, req_id, stop_cause
// out      | out_valid_o / out_ready_i | status, resend_*, missing_set,
//          |                           | pending_now, broadcast_active
//
// one item per cycle sustained while the output is not stalled; a taken item loads the
// input register, then its result loads the result register, where it is valid
// the tracker state is updated in the same cycle that the result register loads
// reset clears the tracker state and loads register defaults; cfg is always ready
// a stalled output holds the result and the input register, backing up in_ready_o

module stop_broadcast_ack_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [sbat_pkg::TimeW-1:0]  now_time_i,
  input  logic [1:0]                  msg_kind_i,
  input  logic [sbat_pkg::NodeW-1:0]  msg_source_i,
  input  logic [sbat_pkg::NodeW-1:0]  bound_source_i,
  input  logic [sbat_pkg::IdW-1:0]    req_id_i,
  input  logic [sbat_pkg::CauseW-1:0] stop_cause_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        resend_valid_o,
  output logic [sbat_pkg::IdW-1:0]    resend_id_o,
  output logic [sbat_pkg::CauseW-1:0] resend_cause_o,
  output logic [sbat_pkg::PeerW-1:0]  missing_set_o,
  output logic [sbat_pkg::PeerW-1:0]  pending_now_o,
  output logic                        broadcast_active_o
);

  import sbat_pkg::*;

  // configuration registers
  logic [LocalW-1:0] local_node_q;
  logic [PeerW-1:0]  peer_set_q;
  logic [TimeW-1:0]  retry_interval_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_node_q     <= LocalNodeRst;
      peer_set_q       <= '0;
      retry_interval_q <= RetryIntervalRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLocalNode:     local_node_q     <= cfg_data_i[LocalW-1:0];
        RegPeerSet:       peer_set_q       <= cfg_data_i[PeerW-1:0] & PeerFieldMask;
        RegRetryInterval: retry_interval_q <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_vld_q;
  logic [1:0]        op_q;
  logic [TimeW-1:0]  now_q;
  logic [1:0]        kind_q;
  logic [NodeW-1:0]  src_q;
  logic [NodeW-1:0]  bound_q;
  logic [IdW-1:0]    rid_q;
  logic [CauseW-1:0] cause_q;

  logic out_vld_q;
  logic advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q    <= opcode_i;
      now_q   <= now_time_i;
      kind_q  <= msg_kind_i;
      src_q   <= msg_source_i;
      bound_q <= bound_source_i;
      rid_q   <= req_id_i;
      cause_q <= stop_cause_i;
    end
  end

  // tracker state
  logic [IdW-1:0]    active_id_q, active_id_d;
  logic [CauseW-1:0] active_cause_q, active_cause_d;
  logic [PeerW-1:0]  pending_q, pending_d;
  logic [TimeW-1:0]  deadline_q, deadline_d;
  logic              in_prog_q, in_prog_d;

  // result values
  logic [1:0]        st_d;
  logic              rs_vld_d;
  logic [IdW-1:0]    rs_id_d;
  logic [CauseW-1:0] rs_cause_d;
  logic [PeerW-1:0]  rs_missing_d;

  logic [NodeW-1:0]  local_ext;
  logic [PeerW-1:0]  begin_mask;
  logic [PeerW-1:0]  ack_bit;
  logic [TimeW-1:0]  since_deadline;
  logic [TimeW-1:0]  next_deadline;

  assign local_ext      = NodeW'(local_node_q);
  assign begin_mask     = peer_set_q & ~node_bit(local_ext) & PeerFieldMask;
  assign ack_bit        = node_bit(bound_q);
  assign since_deadline = now_q - deadline_q;
  assign next_deadline  = now_q + retry_interval_q;

  // per-item update
  always_comb begin
    active_id_d    = active_id_q;
    active_cause_d = active_cause_q;
    pending_d      = pending_q;
    deadline_d     = deadline_q;
    in_prog_d      = in_prog_q;
    st_d           = StBadArg;
    rs_vld_d       = 1'b0;
    rs_id_d        = '0;
    rs_cause_d     = '0;
    rs_missing_d   = '0;

    case (op_q)
      OpBegin: begin
        if (kind_q != KindStopReq || !node_ok(local_ext) || src_q != local_ext ||
            rid_q == '0) begin
          st_d = StBadArg;
        end else begin
          active_id_d    = rid_q;
          active_cause_d = cause_q;
          pending_d      = begin_mask;
          deadline_d     = next_deadline;
          in_prog_d      = begin_mask != '0;
          st_d           = StOk;
        end
      end
      OpAck: begin
        if (!node_ok(bound_q)) begin
          st_d = StBadArg;
        end else if (kind_q != KindStopAck || src_q != bound_q) begin
          st_d = StBadValue;
        end else if (!in_prog_q || rid_q != active_id_q) begin
          st_d = StEmpty;
        end else if ((pending_q & ack_bit) == '0) begin
          st_d = StEmpty;
        end else begin
          pending_d = pending_q & ~ack_bit;
          if ((pending_q & ~ack_bit) == '0) begin
            in_prog_d = 1'b0;
          end
          st_d = StOk;
        end
      end
      OpTick: begin
        if (!in_prog_q || pending_q == '0) begin
          st_d = StEmpty;
        end else if (since_deadline[TimeW-1]) begin
          st_d = StEmpty;
        end else begin
          rs_vld_d     = 1'b1;
          rs_id_d      = active_id_q;
          rs_cause_d   = active_cause_q;
          rs_missing_d = pending_q;
          deadline_d   = next_deadline;
          st_d         = StOk;
        end
      end
      default: begin
        st_d = StBadArg;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_id_q    <= '0;
      active_cause_q <= '0;
      pending_q      <= '0;
      deadline_q     <= '0;
      in_prog_q      <= 1'b0;
    end else if (advance) begin
      active_id_q    <= active_id_d;
      active_cause_q <= active_cause_d;
      pending_q      <= pending_d;
      deadline_q     <= deadline_d;
      in_prog_q      <= in_prog_d;
    end
  end

  // result register
  logic [1:0]        st_q;
  logic              rs_vld_q;
  logic [IdW-1:0]    rs_id_q;
  logic [CauseW-1:0] rs_cause_q;
  logic [PeerW-1:0]  rs_missing_q;
  logic [PeerW-1:0]  pend_out_q;
  logic              active_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_q         <= st_d;
      rs_vld_q     <= rs_vld_d;
      rs_id_q      <= rs_id_d;
      rs_cause_q   <= rs_cause_d;
      rs_missing_q <= rs_missing_d;
      pend_out_q   <= pending_d;
      active_out_q <= in_prog_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = st_q;
  assign resend_valid_o     = rs_vld_q;
  assign resend_id_o        = rs_id_q;
  assign resend_cause_o     = rs_cause_q;
  assign missing_set_o      = rs_missing_q;
  assign pending_now_o      = pend_out_q;
  assign broadcast_active_o = active_out_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sbat_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] OpUnused  = 2'd3;
  localparam logic [1:0] KindOther = 2'd2;

  localparam int unsigned MaxReports    = 10;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int          PhaseCount    = 10;

  // one input transaction
  typedef struct packed {
    logic [1:0]        opcode;
    logic [TimeW-1:0]  now_time;
    logic [1:0]        msg_kind;
    logic [NodeW-1:0]  msg_source;
    logic [NodeW-1:0]  bound_source;
    logic [IdW-1:0]    req_id;
    logic [CauseW-1:0] stop_cause;
  } stop_item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]        status;
    logic              resend_valid;
    logic [IdW-1:0]    resend_id;
    logic [CauseW-1:0] resend_cause;
    logic [PeerW-1:0]  missing_set;
    logic [PeerW-1:0]  pending_now;
    logic              broadcast_active;
  } tracker_result_t;

  // tracker prediction and in-order result checking
  class ack_tracker_scoreboard;
    logic [LocalW-1:0] my_node;
    logic [PeerW-1:0]  my_peers;
    logic [TimeW-1:0]  my_interval;
    logic [IdW-1:0]    bcast_id;
    logic [CauseW-1:0] bcast_cause;
    logic [PeerW-1:0]  waiting_peers;
    logic [TimeW-1:0]  resend_at;
    logic              bcast_live;
    tracker_result_t   outcomes_due[$];
    int unsigned       mismatches;

    function new();
      my_node       = LocalNodeRst;
      my_peers      = '0;
      my_interval   = RetryIntervalRst;
      bcast_id      = '0;
      bcast_cause   = '0;
      waiting_peers = '0;
      resend_at     = '0;
      bcast_live    = 1'b0;
      mismatches    = 0;
    endfunction

    function bit node_in_range(logic [NodeW-1:0] n);
      return (n >= NodeW'(1)) && (n <= NodeW'(NodeCount));
    endfunction

    function logic [PeerW-1:0] peer_bit(logic [NodeW-1:0] n);
      logic [PeerW-1:0] b;
      b = '0;
      if (node_in_range(n)) b[n - NodeW'(1)] = 1'b1;
      return b;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        RegLocalNode:     my_node = data[LocalW-1:0];
        RegPeerSet:       my_peers = data[PeerW-1:0];
        RegRetryInterval: my_interval = data;
        default: ;
      endcase
    endfunction

    // accepted input: update the tracker copy and queue its result
    function void take_request(stop_item_t it);
      tracker_result_t  r;
      logic [PeerW-1:0] ack_bit;
      logic [TimeW-1:0] lag;
      r = '0;
      r.status = StBadArg;
      ack_bit = peer_bit(it.bound_source);
      case (it.opcode)
        OpBegin: begin
          if (it.msg_kind == KindStopReq && node_in_range(NodeW'(my_node)) &&
              it.msg_source == NodeW'(my_node) && it.req_id != '0) begin
            bcast_id      = it.req_id;
            bcast_cause   = it.stop_cause;
            waiting_peers = my_peers & ~peer_bit(NodeW'(my_node));
            resend_at     = it.now_time + my_interval;
            bcast_live    = (waiting_peers != '0);
            r.status      = StOk;
          end
        end
        OpAck: begin
          if (!node_in_range(it.bound_source)) begin
            r.status = StBadArg;
          end else if (it.msg_kind != KindStopAck || it.msg_source != it.bound_source) begin
            r.status = StBadValue;
          end else if (!bcast_live || it.req_id != bcast_id ||
                       (waiting_peers & ack_bit) == '0) begin
            r.status = StEmpty;
          end else begin
            waiting_peers = waiting_peers & ~ack_bit;
            if (waiting_peers == '0) bcast_live = 1'b0;
            r.status = StOk;
          end
        end
        OpTick: begin
          // due once now is at or past the deadline, modulo 2^32
          lag = it.now_time - resend_at;
          if (!bcast_live || waiting_peers == '0 || lag[TimeW-1]) begin
            r.status = StEmpty;
          end else begin
            r.status       = StOk;
            r.resend_valid = 1'b1;
            r.resend_id    = bcast_id;
            r.resend_cause = bcast_cause;
            r.missing_set  = waiting_peers;
            resend_at      = it.now_time + my_interval;
          end
        end
        default: ;
      endcase
      r.pending_now      = waiting_peers;
      r.broadcast_active = bcast_live;
      outcomes_due.push_back(r);
    endfunction

    function string show(tracker_result_t r);
      return $sformatf("st %0d rs %0b id %h cause %h miss %h pend %h act %0b",
                       r.status, r.resend_valid, r.resend_id, r.resend_cause,
                       r.missing_set, r.pending_now, r.broadcast_active);
    endfunction

    // accepted result: compare against the oldest prediction
    function void check_outcome(tracker_result_t got);
      tracker_result_t want;
      bit              bad;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("unexpected result: %s", show(got));
        return;
      end
      want = outcomes_due.pop_front();
      bad = (got.status !== want.status) || (got.resend_valid !== want.resend_valid) ||
            (got.resend_id !== want.resend_id) ||
            (got.resend_cause !== want.resend_cause) ||
            (got.missing_set !== want.missing_set) ||
            (got.pending_now !== want.pending_now) ||
            (got.broadcast_active !== want.broadcast_active);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("mismatch expected: %s", show(want));
          $display("         actual:   %s", show(got));
        end
      end
    endfunction

    function int unsigned outstanding();
      return outcomes_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;

  logic              in_valid;
  logic              in_ready;
  logic [1:0]        opcode;
  logic [TimeW-1:0]  now_time;
  logic [1:0]        msg_kind;
  logic [NodeW-1:0]  msg_source;
  logic [NodeW-1:0]  bound_source;
  logic [IdW-1:0]    req_id;
  logic [CauseW-1:0] stop_cause;

  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic              resend_valid;
  logic [IdW-1:0]    resend_id;
  logic [CauseW-1:0] resend_cause;
  logic [PeerW-1:0]  missing_set;
  logic [PeerW-1:0]  pending_now;
  logic              broadcast_active;

  ack_tracker_scoreboard sb;

  // stimulus shaping shared between processes
  bit                calm;
  bit                hold_rx;
  logic [TimeW-1:0]  t_now;
  logic [IdW-1:0]    last_id;
  logic [LocalW-1:0] gen_node;
  logic [PeerW-1:0]  gen_peers;

  stop_broadcast_ack_tracker u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .opcode_i           (opcode),
    .now_time_i         (now_time),
    .msg_kind_i         (msg_kind),
    .msg_source_i       (msg_source),
    .bound_source_i     (bound_source),
    .req_id_i           (req_id),
    .stop_cause_i       (stop_cause),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status),
    .resend_valid_o     (resend_valid),
    .resend_id_o        (resend_id),
    .resend_cause_o     (resend_cause),
    .missing_set_o      (missing_set),
    .pending_now_o      (pending_now),
    .broadcast_active_o (broadcast_active)
  );

  always #4 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_outcome('{status, resend_valid, resend_id, resend_cause,
                         missing_set, pending_now, broadcast_active});
    end
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_left = HoldCycles;
        hold_rx = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // one register write; valid is left high for a following write
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [LocalW-1:0] node, input logic [PeerW-1:0] peers,
                            input logic [TimeW-1:0] interval);
    cfg_write(RegLocalNode, 32'(node));
    cfg_write(RegPeerSet, 32'(peers));
    cfg_write(RegRetryInterval, interval);
    cfg_valid <= 1'b0;
    gen_node  = node;
    gen_peers = peers;
  endtask

  // drive one input transaction and hold it until taken
  task automatic send_item(input stop_item_t it);
    in_valid     <= 1'b1;
    opcode       <= it.opcode;
    now_time     <= it.now_time;
    msg_kind     <= it.msg_kind;
    msg_source   <= it.msg_source;
    bound_source <= it.bound_source;
    req_id       <= it.req_id;
    stop_cause   <= it.stop_cause;
    do @(posedge clk); while (!in_ready);
    sb.take_request(it);
  endtask

  task automatic offer(input stop_item_t it);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    send_item(it);
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // mostly well-formed broadcasts, acks and ticks, plus noise
  task automatic make_item(output stop_item_t it);
    int unsigned      pick;
    logic [NodeW-1:0] n;
    pick = $urandom_range(0, 99);
    t_now = t_now + TimeW'($urandom_range(0, 12));
    if ($urandom_range(0, 19) == 0) t_now = $urandom;
    it.opcode       = OpTick;
    it.now_time     = t_now;
    it.msg_kind     = 2'($urandom_range(0, 3));
    it.msg_source   = NodeW'($urandom_range(0, 255));
    it.bound_source = NodeW'($urandom_range(0, 255));
    it.req_id       = $urandom;
    it.stop_cause   = CauseW'($urandom_range(0, 255));
    if (pick < 9) begin
      it.opcode     = OpBegin;
      it.msg_kind   = KindStopReq;
      it.msg_source = NodeW'(gen_node);
      if (it.req_id == '0) it.req_id = IdW'(1);
      last_id = it.req_id;
    end else if (pick < 14) begin
      // begin with some of its checks broken
      it.opcode = OpBegin;
      if ($urandom_range(0, 1)) it.msg_kind = KindStopReq;
      if ($urandom_range(0, 1)) it.msg_source = NodeW'(gen_node);
      if ($urandom_range(0, 1)) it.req_id = '0;
    end else if (pick < 58) begin
      // ack from a peer, biased toward configured peers
      n = NodeW'($urandom_range(1, NodeCount));
      repeat (8) begin
        if (gen_peers != '0 && !gen_peers[n - NodeW'(1)]) begin
          n = NodeW'($urandom_range(1, NodeCount));
        end
      end
      it.opcode       = OpAck;
      it.msg_kind     = KindStopAck;
      it.msg_source   = n;
      it.bound_source = n;
      it.req_id       = last_id;
    end else if (pick < 68) begin
      it.opcode = OpAck;
      if ($urandom_range(0, 1)) it.bound_source = NodeW'($urandom_range(0, 12));
      if ($urandom_range(0, 1)) it.msg_source = it.bound_source;
      if ($urandom_range(0, 1)) it.msg_kind = KindStopAck;
      if ($urandom_range(0, 1)) it.req_id = last_id;
    end else if (pick >= 94) begin
      it.opcode = $urandom_range(0, 1) ? OpUnused : 2'($urandom_range(0, 3));
    end
  endtask

  initial begin : stimulus
    int                p;
    int                k;
    int                count;
    stop_item_t        it;
    logic [LocalW-1:0] node;
    logic [PeerW-1:0]  peers;
    logic [TimeW-1:0]  ivl;

    sb = new();
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = RegLocalNode;
    cfg_data     = '0;
    in_valid     = 1'b0;
    opcode       = OpBegin;
    now_time     = '0;
    msg_kind     = KindStopReq;
    msg_source   = '0;
    bound_source = '0;
    req_id       = '0;
    stop_cause   = '0;
    calm         = 1'b0;
    hold_rx      = 1'b0;
    t_now        = '0;
    last_id      = IdW'(1);
    gen_node     = LocalNodeRst;
    gen_peers    = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases, local node 3 with every peer listed
    set_config(LocalW'(3), PeerFieldMask, TimeW'(100));
    offer('{OpTick, 32'd5, KindOther, 8'd0, 8'd0, 32'd0, 8'd0});
    offer('{OpAck, 32'd6, KindStopAck, 8'd2, 8'd2, 32'd7, 8'd0});
    offer('{OpUnused, 32'hFFFF_FFFF, OpUnused, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF});
    // rejected begins: wrong kind, wrong source, zero id, source high bits set
    offer('{OpBegin, 32'd8, KindStopAck, 8'd3, 8'd0, 32'd9, 8'd1});
    offer('{OpBegin, 32'd8, KindStopReq, 8'd4, 8'd0, 32'd9, 8'd1});
    offer('{OpBegin, 32'd8, KindStopReq, 8'd3, 8'd0, 32'd0, 8'd1});
    offer('{OpBegin, 32'd8, KindStopReq, 8'h13, 8'd0, 32'd9, 8'd1});
    // accepted begin whose deadline wraps past zero
    offer('{OpBegin, 32'hFFFF_FFC0, KindStopReq, 8'd3, 8'd0, 32'hFFFF_FFFF, 8'hFF});
    offer('{OpTick, 32'hFFFF_FFF0, KindOther, 8'd0, 8'd0, 32'd0, 8'd0});
    // acks with bad bound source, bad kind, source mismatch, other id
    offer('{OpAck, 32'd0, KindStopAck, 8'd0, 8'd0, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopAck, 8'd11, 8'd11, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopAck, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopReq, 8'd2, 8'd2, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopAck, 8'd5, 8'd2, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopAck, 8'd2, 8'd2, 32'hFFFF_FFFE, 8'd0});
    // local bit never pending, then a real ack and its repeat
    offer('{OpAck, 32'd0, KindStopAck, 8'd3, 8'd3, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopAck, 8'd1, 8'd1, 32'hFFFF_FFFF, 8'd0});
    offer('{OpAck, 32'd0, KindStopAck, 8'd1, 8'd1, 32'hFFFF_FFFF, 8'd0});
    // tick exactly at the wrapped deadline resends
    offer('{OpTick, 32'h24, KindOther, 8'd0, 8'd0, 32'd0, 8'd0});
    offer('{OpAck, 32'h25, KindStopAck, 8'd10, 8'd10, 32'hFFFF_FFFF, 8'd0});
    // new begin replaces the live broadcast
    offer('{OpBegin, 32'd0, KindStopReq, 8'd3, 8'd0, 32'd1, 8'd0});
    offer('{OpTick, 32'h1000, KindOther, 8'd0, 8'd0, 32'd0, 8'd0});
    offer('{OpTick, 32'h1000, KindOther, 8'd0, 8'd0, 32'd0, 8'd0});
    in_valid <= 1'b0;
    drain();

    // random phases over a spread of register settings
    for (p = 0; p < PhaseCount; p++) begin
      node  = LocalW'($urandom_range(1, NodeCount));
      peers = PeerW'($urandom_range(0, 1023) & $urandom_range(0, 1023));
      ivl   = TimeW'($urandom_range(1, 80));
      case (p)
        0: begin node = LocalW'(1);  peers = PeerFieldMask; ivl = '0; end
        1: begin node = LocalW'(10); peers = PeerFieldMask; ivl = '1; end
        2: begin node = LocalW'(5);  ivl = TimeW'(37); end
        3: begin node = LocalW'(4);  peers = PeerW'(10'h008); ivl = TimeW'(25); end
        4: begin node = LocalW'(0);  peers = '0; ivl = TimeW'(20); end
        5: begin node = LocalW'(15); peers = PeerW'(10'h155); ivl = TimeW'(10); end
        9: begin peers = PeerFieldMask; ivl = 32'h8000_0000; end
        default: ;
      endcase
      set_config(node, peers, ivl);
      count = (p >= 3 && p <= 5) ? 20 : 65;
      calm = (p == 8);
      if (p == 6) hold_rx = 1'b1;
      for (k = 0; k < count; k++) begin
        make_item(it);
        if (p == 7 && k == count / 2) begin
          // sender waits for every outstanding result
          in_valid <= 1'b0;
          drain();
          send_item(it);
        end else begin
          offer(it);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
